[rtl/core/tlw_pkg.sv]
package tlw_pkg;

   // configuration of the lookup store
   localparam int NUM_STATES  = 256;
   localparam int MAX_OUTPUTS = 8;
   localparam int VALUE_WIDTH = 32;

   // fixed field widths of a word
   localparam int TYPE_W   = 2;
   localparam int STATE_W  = 8;
   localparam int SYMBOL_W = 8;
   localparam int WEIGHT_W = 32;
   localparam int SLOT_W   = 3;

   // only states and slots the fields can name are stored
   localparam int STATE_DEPTH = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
   localparam int STATE_AW    = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
   localparam int TRANS_AW    = STATE_AW + SYMBOL_W;
   localparam int OUT_SLOTS   = (MAX_OUTPUTS < (1 << SLOT_W)) ? MAX_OUTPUTS : (1 << SLOT_W);
   localparam int SLOT_AW     = (OUT_SLOTS > 1) ? $clog2(OUT_SLOTS) : 1;
   localparam int OUT_AW      = STATE_AW + SLOT_AW;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // register file
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;
   localparam int CSR_IDX_BIT    = 2;
   localparam logic CSR_START_STATE = 1'b0;

   // request codes on the input channel
   localparam logic [TYPE_W-1:0] REQ_TRANS_WR = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FINAL_WR = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SYMBOL   = 2'd2;

   typedef enum logic [1:0] {
      OP_TRANS_WR,
      OP_FINAL_WR,
      OP_SYMBOL
   } op_type;

   typedef enum logic [2:0] {
      EX_CLEAR,
      EX_IDLE,
      EX_STEP,
      EX_FINAL,
      EX_MASK,
      EX_SLOT_RD,
      EX_SLOT_EMIT
   } exec_state_type;

   typedef struct packed {
      op_type                  op;
      logic [STATE_W-1:0]      state_index;
      logic [SYMBOL_W-1:0]     symbol;
      logic [STATE_W-1:0]      next_state;
      logic [VALUE_WIDTH-1:0]  weight;
      logic                    entry_valid;
      logic [SLOT_AW-1:0]      slot;
      logic                    first;
      logic                    last;
   } tlw_entry_type;

   typedef struct packed {
      logic                    present;
      logic [STATE_W-1:0]      next_state;
      logic [VALUE_WIDTH-1:0]  weight;
   } trans_word_type;

   function automatic logic state_ok(input logic [STATE_W-1:0] s);
      return 32'(s) < NUM_STATES;
   endfunction

   function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
      return 32'(s) < MAX_OUTPUTS;
   endfunction

endpackage

[rtl/core/tlw_req_if.sv]
interface tlw_req_if;
   import tlw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TYPE_W-1:0]    req_type;
   logic [STATE_W-1:0]   state_index;
   logic [SYMBOL_W-1:0]  symbol;
   logic [STATE_W-1:0]   next_state;
   logic [WEIGHT_W-1:0]  weight;
   logic                 entry_valid;
   logic [SLOT_W-1:0]    slot;
   logic                 last_symbol;

   modport source (
      output valid, req_type, state_index, symbol, next_state, weight, entry_valid, slot,
             last_symbol,
      input  ready
   );

   modport sink (
      input  valid, req_type, state_index, symbol, next_state, weight, entry_valid, slot,
             last_symbol,
      output ready
   );

endinterface

[rtl/core/tlw_rsp_if.sv]
interface tlw_rsp_if;
   import tlw_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    matched;
   logic [VALUE_WIDTH-1:0]  value;
   logic                    last;

   modport source (
      output valid, matched, value, last,
      input  ready
   );

   modport sink (
      input  valid, matched, value, last,
      output ready
   );

endinterface

[rtl/core/tlw_front.sv]
module tlw_front (
   input  logic                  clock,
   input  logic                  reset,
   tlw_req_if.sink               req_chan,
   input  logic                  q_full,
   input  logic                  clearing,
   output logic                  q_push,
   output tlw_pkg::tlw_entry_type q_entry
);
   import tlw_pkg::*;

   logic mid_word_ff;
   logic mid_word_in;
   logic accept;
   logic keep;
   op_type op;

   assign req_chan.ready = !q_full && !clearing;
   assign accept         = req_chan.valid && req_chan.ready;

   // out-of-range writes and unknown codes are taken and dropped here
   always_comb begin
      keep = 1'b0;
      op   = OP_SYMBOL;
      unique case (req_chan.req_type)
         REQ_TRANS_WR: begin
            op   = OP_TRANS_WR;
            keep = state_ok(req_chan.state_index);
         end
         REQ_FINAL_WR: begin
            op   = OP_FINAL_WR;
            keep = state_ok(req_chan.state_index) && slot_ok(req_chan.slot);
         end
         REQ_SYMBOL: begin
            op   = OP_SYMBOL;
            keep = 1'b1;
         end
         default: begin
            op   = OP_SYMBOL;
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = accept && keep;

   always_comb begin
      q_entry.op          = op;
      q_entry.state_index = req_chan.state_index;
      q_entry.symbol      = req_chan.symbol;
      q_entry.next_state  = req_chan.next_state;
      q_entry.weight      = VALUE_WIDTH'(req_chan.weight);
      q_entry.entry_valid = req_chan.entry_valid;
      q_entry.slot        = SLOT_AW'(req_chan.slot);
      q_entry.first       = !mid_word_ff;
      q_entry.last        = req_chan.last_symbol;
   end

   always_comb begin
      mid_word_in = mid_word_ff;
      if (accept && (req_chan.req_type == REQ_SYMBOL)) begin
         mid_word_in = !req_chan.last_symbol;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_word_ff <= 1'b0;
      end else begin
         mid_word_ff <= mid_word_in;
      end
   end

endmodule

[rtl/core/tlw_queue.sv]
module tlw_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tlw_pkg::tlw_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   nonempty,
   output tlw_pkg::tlw_entry_type head
);
   import tlw_pkg::*;

   tlw_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/tlw_exec.sv]
module tlw_exec (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  tlw_pkg::tlw_entry_type        q_head,
   output logic                          q_pop,
   input  logic [tlw_pkg::STATE_W-1:0]   start_state,
   output logic                          clearing,
   tlw_rsp_if.source                     rsp_chan
);
   import tlw_pkg::*;

   localparam int TRANS_DEPTH = 1 << TRANS_AW;
   localparam int MASK_DEPTH  = 1 << STATE_AW;
   localparam int VALUE_DEPTH = 1 << OUT_AW;

   exec_state_type state_ff;
   exec_state_type state_in;

   logic [TRANS_AW-1:0]     clr_cnt_ff;
   logic [STATE_W-1:0]      cur_state_ff;
   logic [VALUE_WIDTH-1:0]  sum_ff;
   logic                    failed_ff;
   logic                    last_sym_ff;
   logic [OUT_SLOTS-1:0]    pending_ff;
   logic                    slot_last_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_matched_ff;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff;
   logic                    rsp_last_ff;

   trans_word_type          trans_mem [TRANS_DEPTH];
   trans_word_type          trans_rd_ff;
   logic [OUT_SLOTS-1:0]    mask_mem [MASK_DEPTH];
   logic [OUT_SLOTS-1:0]    mask_rd_ff;
   logic [VALUE_WIDTH-1:0]  value_mem [VALUE_DEPTH];
   logic [VALUE_WIDTH-1:0]  value_rd_ff;

   logic                    out_free;
   logic [STATE_W-1:0]      eff_state;
   logic [VALUE_WIDTH-1:0]  eff_sum;
   logic                    eff_failed;
   logic [SLOT_AW-1:0]      low_slot;
   logic [OUT_SLOTS-1:0]    pending_left;

   logic                    trans_we;
   logic [TRANS_AW-1:0]     trans_waddr;
   trans_word_type          trans_wdata;
   logic                    trans_re;
   logic [TRANS_AW-1:0]     trans_raddr;
   logic                    mask_clr;
   logic                    mask_we;
   logic                    mask_re;
   logic                    value_we;
   logic                    value_re;
   logic [OUT_AW-1:0]       value_raddr;
   logic                    emit;
   logic                    emit_matched;
   logic [VALUE_WIDTH-1:0]  emit_value;
   logic                    emit_last;

   function automatic logic [SLOT_AW-1:0] lowest_slot(input logic [OUT_SLOTS-1:0] bits);
      logic [SLOT_AW-1:0] k;
      k = '0;
      for (int i = OUT_SLOTS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            k = SLOT_AW'(i);
         end
      end
      return k;
   endfunction

   assign clearing = (state_ff == EX_CLEAR);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // first byte of a word restarts the walk from the start register
   assign eff_state  = q_head.first ? start_state : cur_state_ff;
   assign eff_sum    = q_head.first ? '0 : sum_ff;
   assign eff_failed = q_head.first ? 1'b0 : failed_ff;

   assign low_slot     = lowest_slot(pending_ff);
   assign pending_left = pending_ff & ~(OUT_SLOTS'(1) << low_slot);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EX_CLEAR: begin
            if (clr_cnt_ff == '1) begin
               state_in = EX_IDLE;
            end
         end
         EX_IDLE: begin
            if (q_valid && (q_head.op == OP_SYMBOL)) begin
               priority if (trans_re) begin
                  state_in = EX_STEP;
               end else if (q_head.last) begin
                  state_in = EX_FINAL;
               end else begin
                  state_in = EX_IDLE;
               end
            end
         end
         EX_STEP: begin
            state_in = last_sym_ff ? EX_FINAL : EX_IDLE;
         end
         EX_FINAL: begin
            if (failed_ff || !state_ok(cur_state_ff)) begin
               state_in = out_free ? EX_IDLE : EX_FINAL;
            end else begin
               state_in = EX_MASK;
            end
         end
         EX_MASK: begin
            if (mask_rd_ff == '0) begin
               state_in = out_free ? EX_IDLE : EX_MASK;
            end else begin
               state_in = EX_SLOT_RD;
            end
         end
         EX_SLOT_RD: begin
            state_in = EX_SLOT_EMIT;
         end
         EX_SLOT_EMIT: begin
            if (out_free) begin
               state_in = slot_last_ff ? EX_IDLE : EX_SLOT_RD;
            end
         end
         default: begin
            state_in = EX_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      trans_we     = 1'b0;
      trans_waddr  = {q_head.state_index[STATE_AW-1:0], q_head.symbol};
      trans_wdata  = '{present: q_head.entry_valid, next_state: q_head.next_state,
                       weight: q_head.weight};
      trans_re     = 1'b0;
      trans_raddr  = {eff_state[STATE_AW-1:0], q_head.symbol};
      mask_clr     = 1'b0;
      mask_we      = 1'b0;
      mask_re      = 1'b0;
      value_we     = 1'b0;
      value_re     = 1'b0;
      value_raddr  = {cur_state_ff[STATE_AW-1:0], low_slot};
      emit         = 1'b0;
      emit_matched = 1'b1;
      emit_value   = sum_ff;
      emit_last    = 1'b1;
      unique case (state_ff)
         EX_CLEAR: begin
            trans_we    = 1'b1;
            trans_waddr = clr_cnt_ff;
            trans_wdata = '0;
            mask_clr    = 1'b1;
         end
         EX_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_head.op)
                  OP_TRANS_WR: begin
                     trans_we = 1'b1;
                  end
                  OP_FINAL_WR: begin
                     mask_we  = 1'b1;
                     value_we = 1'b1;
                  end
                  OP_SYMBOL: begin
                     trans_re = !eff_failed && state_ok(eff_state);
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         EX_STEP: begin
            emit = 1'b0;
         end
         EX_FINAL: begin
            if (failed_ff) begin
               emit         = out_free;
               emit_matched = 1'b0;
               emit_value   = '0;
            end else if (!state_ok(cur_state_ff)) begin
               emit = out_free;
            end else begin
               mask_re = 1'b1;
            end
         end
         EX_MASK: begin
            emit = out_free && (mask_rd_ff == '0);
         end
         EX_SLOT_RD: begin
            value_re = 1'b1;
         end
         EX_SLOT_EMIT: begin
            emit       = out_free;
            emit_value = sum_ff + value_rd_ff;
            emit_last  = slot_last_ff;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EX_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == EX_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + TRANS_AW'(1);
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // walk registers; every word reloads them on its first byte
   always_ff @(posedge clock) begin
      if (state_ff == EX_IDLE && q_valid && q_head.op == OP_SYMBOL) begin
         cur_state_ff <= eff_state;
         sum_ff       <= eff_sum;
         failed_ff    <= eff_failed || !state_ok(eff_state);
         last_sym_ff  <= q_head.last;
      end else if (state_ff == EX_STEP) begin
         if (trans_rd_ff.present) begin
            sum_ff       <= sum_ff + trans_rd_ff.weight;
            cur_state_ff <= trans_rd_ff.next_state;
         end else begin
            failed_ff <= 1'b1;
         end
      end
      if (state_ff == EX_MASK) begin
         pending_ff <= mask_rd_ff;
      end else if (state_ff == EX_SLOT_RD) begin
         pending_ff   <= pending_left;
         slot_last_ff <= (pending_left == '0);
      end
      if (emit) begin
         rsp_matched_ff <= emit_matched;
         rsp_value_ff   <= emit_value;
         rsp_last_ff    <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (trans_we) begin
         trans_mem[trans_waddr] <= trans_wdata;
      end
      if (trans_re) begin
         trans_rd_ff <= trans_mem[trans_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mask_clr) begin
         mask_mem[clr_cnt_ff[STATE_AW-1:0]] <= '0;
      end else if (mask_we) begin
         mask_mem[q_head.state_index[STATE_AW-1:0]][q_head.slot] <= q_head.entry_valid;
      end
      if (mask_re) begin
         mask_rd_ff <= mask_mem[cur_state_ff[STATE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[{q_head.state_index[STATE_AW-1:0], q_head.slot}] <= q_head.weight;
      end
      if (value_re) begin
         value_rd_ff <= value_mem[value_raddr];
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.matched = rsp_matched_ff;
   assign rsp_chan.value   = rsp_value_ff;
   assign rsp_chan.last    = rsp_last_ff;

   a_no_word_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EX_CLEAR) |-> !rsp_valid_ff)
      else $error("result word during clearing pass");

   a_miss_is_single_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_matched_ff) |-> (rsp_last_ff && (rsp_value_ff == '0)))
      else $error("missing-path word not a single zero word");

   a_pending_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EX_SLOT_RD) |=> ($countones(pending_ff) < $countones($past(pending_ff))))
      else $error("final output slot not retired");

   a_more_slots_follow: assert property (@(posedge clock) disable iff (reset)
      (emit && !emit_last) |=> (state_ff == EX_SLOT_RD))
      else $error("non-last result without a further slot read");

endmodule

[rtl/core/transducer_word_lookup.sv]
// Weighted word lookup. Table words (transition writes, final-output slot writes) are
// written by the back end from its idle state; a byte of a live walk takes a transition
// memory round trip (read at {state, byte}, then the next state and sum update). On the last
// byte of an unfailed walk, the reached state's final-output mask is read, and each present
// slot takes a value memory read and a result register load. A two-entry queue sits between
// the input side and the back end, and the result register lets one result wait while the
// next byte is taken. After reset the transition store is cleared one entry a cycle:
// 65536 entries with 256 states, during which req_chan.ready stays low (register writes are
// still taken). start_state takes effect at the first byte of the next word.
module transducer_word_lookup (
   input  logic                        clock,
   input  logic                        reset,
   tlw_req_if.sink                     req_chan,
   tlw_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tlw_pkg::CSR_AW-1:0]  paddr,
   input  logic [tlw_pkg::CSR_DW-1:0]  pwdata,
   output logic [tlw_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import tlw_pkg::*;

   logic [STATE_W-1:0]  start_state_ff;
   logic [STATE_W-1:0]  start_state_in;
   logic                csr_write;

   logic                q_push;
   tlw_entry_type       q_push_entry;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   tlw_entry_type       q_head;
   logic                clearing;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      start_state_in = start_state_ff;
      if (csr_write && (paddr[CSR_IDX_BIT] == CSR_START_STATE)) begin
         start_state_in = pwdata[STATE_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_IDX_BIT] == CSR_START_STATE) begin
         prdata = CSR_DW'(start_state_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
      end else begin
         start_state_ff <= start_state_in;
      end
   end

   tlw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .clearing (clearing),
      .q_push   (q_push),
      .q_entry  (q_push_entry)
   );

   tlw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .nonempty   (q_valid),
      .head       (q_head)
   );

   tlw_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .start_state (start_state_ff),
      .clearing    (clearing),
      .rsp_chan    (rsp_chan)
   );

endmodule

[dv/tb_top.sv]
module tb_top;
   import tlw_pkg::*;

   localparam logic [TYPE_W-1:0] REQ_IGNORED      = 2'd3;
   localparam logic [CSR_AW-1:0] START_STATE_ADDR = 3'd0;
   localparam logic [7:0]        HUB_STATE        = 8'h5A;
   localparam int                POOL_SIZE        = 12;
   localparam int                HOLD_CYCLES      = 400;

   typedef struct packed {
      logic [TYPE_W-1:0]   req_type;
      logic [STATE_W-1:0]  state_index;
      logic [SYMBOL_W-1:0] symbol;
      logic [STATE_W-1:0]  next_state;
      logic [WEIGHT_W-1:0] weight;
      logic                entry_valid;
      logic [SLOT_W-1:0]   slot;
      logic                last_symbol;
   } req_word_type;

   typedef struct packed {
      logic                   matched;
      logic [VALUE_WIDTH-1:0] value;
      logic                   last;
   } lookup_result_type;

   class lookup_scoreboard_type;
      bit                     arc_present [65536];
      logic [STATE_W-1:0]     arc_target [65536];
      logic [VALUE_WIDTH-1:0] arc_weight [65536];
      bit                     final_present [NUM_STATES * MAX_OUTPUTS];
      logic [VALUE_WIDTH-1:0] final_value [NUM_STATES * MAX_OUTPUTS];
      logic [STATE_W-1:0]     start_cfg;
      logic [STATE_W-1:0]     walk_state;
      logic [VALUE_WIDTH-1:0] walk_sum;
      bit                     walk_dead;
      bit                     in_word;
      lookup_result_type      pending [$];
      int mismatches, results_checked, words_done, failed_walks, table_writes;

      function void complain(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
      endfunction

      function void queue_result(logic matched, logic [VALUE_WIDTH-1:0] value, logic last);
         lookup_result_type r;
         r.matched = matched;
         r.value   = value;
         r.last    = last;
         pending.insert(pending.size(), r);
      endfunction

      // predicted effect of one accepted input word
      function void take_word(req_word_type w);
         logic [15:0] a;
         int fi, n_out, k;
         case (w.req_type)
            REQ_TRANS_WR: begin
               table_writes++;
               if (int'(w.state_index) < NUM_STATES) begin
                  a = {w.state_index, w.symbol};
                  arc_present[a] = w.entry_valid;
                  arc_target[a]  = w.next_state;
                  arc_weight[a]  = w.weight;
               end
            end
            REQ_FINAL_WR: begin
               table_writes++;
               if (int'(w.state_index) < NUM_STATES && int'(w.slot) < MAX_OUTPUTS) begin
                  fi = int'(w.state_index) * MAX_OUTPUTS + int'(w.slot);
                  final_present[11'(fi)] = w.entry_valid;
                  final_value[11'(fi)]   = w.weight;
               end
            end
            REQ_SYMBOL: begin
               if (!in_word) begin
                  in_word    = 1'b1;
                  walk_dead  = 1'b0;
                  walk_sum   = '0;
                  walk_state = start_cfg;
               end
               if (!walk_dead) begin
                  a = {walk_state, w.symbol};
                  if (int'(walk_state) < NUM_STATES && arc_present[a]) begin
                     walk_sum   = walk_sum + arc_weight[a];
                     walk_state = arc_target[a];
                  end else begin
                     walk_dead = 1'b1;
                  end
               end
               if (w.last_symbol) begin
                  words_done++;
                  if (walk_dead) begin
                     failed_walks++;
                     queue_result(1'b0, '0, 1'b1);
                  end else begin
                     n_out = 0;
                     fi = int'(walk_state) * MAX_OUTPUTS;
                     if (int'(walk_state) < NUM_STATES)
                        for (int s = 0; s < MAX_OUTPUTS; s++)
                           if (final_present[11'(fi + s)]) n_out++;
                     if (n_out == 0) begin
                        queue_result(1'b1, walk_sum, 1'b1);
                     end else begin
                        k = 0;
                        for (int s = 0; s < MAX_OUTPUTS; s++)
                           if (final_present[11'(fi + s)]) begin
                              k++;
                              queue_result(1'b1, walk_sum + final_value[11'(fi + s)],
                                           k == n_out);
                           end
                     end
                  end
                  in_word    = 1'b0;
                  walk_dead  = 1'b0;
                  walk_sum   = '0;
                  walk_state = start_cfg;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic matched, logic [VALUE_WIDTH-1:0] value, logic last);
         lookup_result_type exp;
         results_checked++;
         if (pending.size() == 0) begin
            complain($sformatf("unexpected result matched=%0d value=%h last=%0d",
                               matched, value, last));
            return;
         end
         exp = pending.pop_front();
         if (matched !== exp.matched || value !== exp.value || last !== exp.last)
            complain($sformatf("result: expected matched=%0d value=%h last=%0d, got %0d %h %0d",
                               exp.matched, exp.value, exp.last, matched, value, last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                psel, penable, pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   tlw_req_if req_chan ();
   tlw_rsp_if rsp_chan ();

   transducer_word_lookup dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   lookup_scoreboard_type sb = new;
   logic [STATE_W-1:0] pool [POOL_SIZE];
   int stall_pct = 0;
   int hold_seq  = 0;
   int hold_len  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin : result_sink
      int hold_left;
      int seen_seq;
      hold_left = 0;
      seen_seq  = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.matched, rsp_chan.value, rsp_chan.last);
         if (hold_seq != seen_seq) begin
            seen_seq  = hold_seq;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic req_word_type mk_word(logic [1:0] t, logic [7:0] st, logic [7:0] sym,
                                            logic [7:0] nxt, logic [31:0] wt, int v,
                                            int sl, int lst);
      return '{t, st, sym, nxt, wt, 1'(v), 3'(sl), 1'(lst)};
   endfunction

   // prefer a symbol that has a transition out of st, so walks go deep
   function automatic logic [7:0] pick_symbol(logic [7:0] st);
      logic [7:0] hits [256];
      int n_hits;
      n_hits = 0;
      for (int s = 0; s < 256; s++)
         if (sb.arc_present[{st, 8'(s)}]) begin
            hits[8'(n_hits)] = 8'(s);
            n_hits++;
         end
      if (n_hits == 0) return 8'($urandom_range(255));
      return hits[8'($urandom_range(n_hits - 1))];
   endfunction

   function automatic logic [7:0] pool_state();
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return pool[4'($urandom_range(POOL_SIZE - 1))];
   endfunction

   task automatic push_word(req_word_type w, int gap_pct);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= w.req_type;
      req_chan.state_index <= w.state_index;
      req_chan.symbol      <= w.symbol;
      req_chan.next_state  <= w.next_state;
      req_chan.weight      <= w.weight;
      req_chan.entry_valid <= w.entry_valid;
      req_chan.slot        <= w.slot;
      req_chan.last_symbol <= w.last_symbol;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.take_word(w);
   endtask

   task automatic csr_access(logic wr, logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= START_STATE_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_start_state(logic [7:0] st);
      logic [CSR_DW-1:0] rd;
      csr_access(1'b1, CSR_DW'(st), rd);
      sb.start_cfg = st;
      if (!sb.in_word) sb.walk_state = st;
      csr_access(1'b0, '0, rd);
      if (rd !== CSR_DW'(st))
         sb.complain($sformatf("start_state readback: expected %h, got %h", st, rd));
   endtask

   // drop valid, let every expected result drain, then allow for trailing table writes
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic directed_words();
      push_word(mk_word(REQ_TRANS_WR, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF, 1, 0, 0), 0);
      push_word(mk_word(REQ_TRANS_WR, 8'hFF, 8'hFF, HUB_STATE, 32'd2, 1, 7, 1), 0);
      push_word(mk_word(REQ_FINAL_WR, HUB_STATE, 8'h00, 8'h00, 32'h10, 1, 0, 0), 0);
      push_word(mk_word(REQ_FINAL_WR, HUB_STATE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1, 7, 0), 0);
      push_word(mk_word(REQ_FINAL_WR, HUB_STATE, 8'h00, 8'h00, 32'h1234_5678, 0, 3, 0), 0);
      // sum wraps to 1, two finals
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h00, 8'h00, 32'd0, 0, 0, 0), 0);
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'hFF, 8'h00, 32'd0, 0, 0, 1), 0);
      // state without finals: sum alone
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h00, 8'h00, 32'd0, 0, 0, 1), 0);
      // missing arc, later bytes skipped
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h01, 8'h00, 32'd0, 0, 0, 0), 0);
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h00, 8'h00, 32'd0, 0, 0, 0), 0);
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'hFF, 8'h00, 32'd0, 0, 0, 1), 0);
      push_word(mk_word(REQ_IGNORED, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1, 7, 1), 0);
      // arc removed, single-byte word fails
      push_word(mk_word(REQ_TRANS_WR, 8'h00, 8'h00, HUB_STATE, 32'd0, 0, 0, 0), 0);
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h00, 8'h00, 32'd0, 0, 0, 1), 0);
      // all eight finals present
      push_word(mk_word(REQ_TRANS_WR, 8'h00, 8'h80, HUB_STATE, 32'd0, 1, 0, 0), 0);
      for (int s = 1; s < 7; s++)
         push_word(mk_word(REQ_FINAL_WR, HUB_STATE, 8'h00, 8'h00, $urandom, 1, s, 0), 0);
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h80, 8'h00, 32'd0, 0, 0, 1), 0);
      // self loop, sum wraps inside the word
      push_word(mk_word(REQ_TRANS_WR, HUB_STATE, 8'h7F, HUB_STATE, 32'h8000_0000, 1, 0, 0), 0);
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h80, 8'h00, 32'd0, 0, 0, 0), 0);
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h7F, 8'h00, 32'd0, 0, 0, 0), 0);
      push_word(mk_word(REQ_SYMBOL, 8'h00, 8'h7F, 8'h00, 32'd0, 0, 0, 1), 0);
   endtask

   // a few arcs and one final per pool state
   task automatic load_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         for (int j = 0; j < 3; j++)
            push_word(mk_word(REQ_TRANS_WR, pool[i], 8'($urandom_range(255)),
                              pool[4'($urandom_range(POOL_SIZE - 1))], $urandom, 1, 0, 0), 0);
         push_word(mk_word(REQ_FINAL_WR, pool[i], 8'h00, 8'h00, $urandom, 1,
                           int'($urandom_range(7)), 0), 0);
      end
   endtask

   task automatic feed_random(int n_items, int gap_pct);
      int sent, bytes_left, r;
      req_word_type w;
      logic [7:0] at;
      sent = 0;
      bytes_left = 0;
      while (sent < n_items || bytes_left > 0) begin
         r = $urandom_range(99);
         w = '{2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
               1'($urandom), 3'($urandom), 1'($urandom)};
         if (r < 12) begin
            w.req_type    = REQ_TRANS_WR;
            w.state_index = pool_state();
            w.next_state  = pool_state();
            w.entry_valid = ($urandom_range(99) < 85);
         end else if (r < 20) begin
            w.req_type    = REQ_FINAL_WR;
            w.state_index = pool_state();
            w.entry_valid = ($urandom_range(99) < 75);
         end else if (r < 23) begin
            w.req_type = REQ_IGNORED;
         end else begin
            if (bytes_left == 0)
               bytes_left = ($urandom_range(9) == 0) ? $urandom_range(6, 12)
                                                     : $urandom_range(1, 4);
            at = sb.in_word ? sb.walk_state : sb.start_cfg;
            w.req_type = REQ_SYMBOL;
            if ($urandom_range(99) < 90) w.symbol = pick_symbol(at);
            w.last_symbol = (bytes_left == 1);
            bytes_left--;
         end
         if (w.req_type != REQ_IGNORED) sent++;
         push_word(w, gap_pct);
      end
   endtask

   initial begin : stimulus
      req_chan.valid       = 1'b0;
      req_chan.req_type    = '0;
      req_chan.state_index = '0;
      req_chan.symbol      = '0;
      req_chan.next_state  = '0;
      req_chan.weight      = '0;
      req_chan.entry_valid = 1'b0;
      req_chan.slot        = '0;
      req_chan.last_symbol = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      pool[0] = 8'h00;
      pool[1] = 8'hFF;
      pool[2] = HUB_STATE;
      for (int i = 3; i < POOL_SIZE; i++) pool[i] = 8'($urandom_range(255));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register write lands during the store clear
      set_start_state(8'h00);
      directed_words();
      settle();

      set_start_state(pool[4'($urandom_range(2, POOL_SIZE - 1))]);
      load_pool();
      feed_random(55, 0);
      settle();

      set_start_state(8'hFF);
      feed_random(55, 45);
      settle();

      stall_pct <= 45;
      set_start_state(8'h00);
      feed_random(55, 0);
      settle();

      stall_pct <= 38;
      set_start_state(pool[4'($urandom_range(POOL_SIZE - 1))]);
      feed_random(55, 38);
      settle();

      // long result hold-off with the input kept busy
      stall_pct <= 10;
      set_start_state(HUB_STATE);
      hold_len <= HOLD_CYCLES;
      hold_seq <= hold_seq + 1;
      feed_random(35, 0);
      settle();

      $display("Walked %0d words (%0d hit a missing transition), %0d table writes, %0d results",
               sb.words_done, sb.failed_walks, sb.table_writes, sb.results_checked);
      $display("Start states 0, 255 and others; idle/stall mixes plus a %0d-cycle hold; %0d bad",
               HOLD_CYCLES, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
